[src/ctpi_pkg.sv]
`default_nettype none

package ctpi_pkg;

  // fixed field widths of the channels
  localparam int IN_W    = 12;
  localparam int A_OUT_W = 27;
  localparam int B_OUT_W = 39;
  localparam int D_OUT_W = 50;

  // coordinate bits in use, 4 to 12
  localparam int COORD_W = 12;

  // internal widths, all signed
  localparam int DIFF_W  = COORD_W + 1;
  localparam int NORM_W  = 2 * COORD_W + 1;
  localparam int CROSS_W = 2 * COORD_W + 1;
  localparam int DN_W    = NORM_W + 1;
  localparam int A_W     = 2 * COORD_W + 3;
  localparam int B_W     = 3 * COORD_W + 4;
  localparam int D_W     = 4 * COORD_W + 4;
  localparam int F_W     = 4 * COORD_W + 6;

  typedef logic signed [IN_W-1:0]    in_field_t;
  typedef logic signed [A_OUT_W-1:0] out_a_t;
  typedef logic signed [B_OUT_W-1:0] out_b_t;
  typedef logic signed [D_OUT_W-1:0] out_d_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [DN_W-1:0]    dn_t;
  typedef logic signed [A_W-1:0]     ca_t;
  typedef logic signed [B_W-1:0]     cb_t;
  typedef logic signed [D_W-1:0]     cd_t;
  typedef logic signed [F_W-1:0]     f_t;

  // coefficients plus the query point, handed to the evaluation stages
  typedef struct packed {
    ca_t    a;
    cb_t    b;
    cb_t    c;
    cd_t    d;
    norm_t  nz;
    coord_t xz;
    coord_t yz;
  } coeff_t;

endpackage

`default_nettype wire

[src/ctpi_if.sv]
`default_nettype none

interface ctpi_in_if;
  logic                valid;
  logic                ready;
  ctpi_pkg::in_field_t p_x;
  ctpi_pkg::in_field_t p_y;
  ctpi_pkg::in_field_t q_x;
  ctpi_pkg::in_field_t q_y;
  ctpi_pkg::in_field_t r_x;
  ctpi_pkg::in_field_t r_y;
  ctpi_pkg::in_field_t query_x;
  ctpi_pkg::in_field_t query_y;

  modport source (
    output valid, p_x, p_y, q_x, q_y, r_x, r_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, p_x, p_y, q_x, q_y, r_x, r_y, query_x, query_y,
    output ready
  );
endinterface

interface ctpi_out_if;
  logic             valid;
  logic             ready;
  ctpi_pkg::out_a_t coeff_a;
  ctpi_pkg::out_b_t coeff_b;
  ctpi_pkg::out_b_t coeff_c;
  ctpi_pkg::out_d_t coeff_d;
  logic             is_inside;

  modport source (
    output valid, coeff_a, coeff_b, coeff_c, coeff_d, is_inside,
    input  ready
  );
  modport sink (
    input  valid, coeff_a, coeff_b, coeff_c, coeff_d, is_inside,
    output ready
  );
endinterface

`default_nettype wire

[src/circle_three_points_inside_test.sv]
// throughput: one item per cycle while the output accepts, five register stages each with its own valid bit
// a stage refills as soon as its content moves on, so bubbles close up under stall
// reset (rst_ni, async, active low) clears all valid bits and the invert register
// payload registers are not reset
`default_nettype none

module circle_three_points_inside_test (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         invert_we_i,
  input  wire         invert_wdata_i,
  ctpi_in_if.sink     in_i,
  ctpi_out_if.source  out_o
);

  logic             invert_q;
  logic             mid_valid;
  logic             mid_ready;
  ctpi_pkg::coeff_t mid_coeff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (invert_we_i) begin
      invert_q <= invert_wdata_i;
    end
  end

  ctpi_coeff u_coeff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .ready_i (mid_ready),
    .valid_o (mid_valid),
    .coeff_o (mid_coeff)
  );

  ctpi_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .invert_i (invert_q),
    .valid_i  (mid_valid),
    .ready_o  (mid_ready),
    .coeff_i  (mid_coeff),
    .out_o    (out_o)
  );

`ifndef ASSERT_OFF
  // a free output slot must open the whole stage chain back to the input
  a_ready_chain: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready
  ) else $error("input not ready while output ready");

  // with no quadratic or linear terms f is just d
  a_const_only: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.coeff_a == 0 && out_o.coeff_b == 0 && out_o.coeff_c == 0)
      |-> (out_o.is_inside == out_o.coeff_d[ctpi_pkg::D_OUT_W-1])
  ) else $error("inside flag disagrees with constant term");
`endif

endmodule

`default_nettype wire

[src/ctpi_coeff.sv]
`default_nettype none

module ctpi_coeff (
  input  wire              clk_i,
  input  wire              rst_ni,
  ctpi_in_if.sink          in_i,
  input  wire              ready_i,
  output logic             valid_o,
  output ctpi_pkg::coeff_t coeff_o
);

  // stage 1: differences, norms, 2x2 cross terms
  ctpi_pkg::coord_t xp, yp, xq, yq, xr, yr, xz, yz;
  ctpi_pkg::diff_t  dxq_d, dyq_d, dxr_d, dyr_d;
  ctpi_pkg::diff_t  dxq_q, dyq_q, dxr_q, dyr_q;
  ctpi_pkg::norm_t  np1_d, nq1_d, nr1_d, nz1_d;
  ctpi_pkg::norm_t  np1_q, nq1_q, nr1_q, nz1_q;
  ctpi_pkg::cross_t k1_d, k2_d, k3_d;
  ctpi_pkg::cross_t k1_q, k2_q, k3_q;
  ctpi_pkg::coord_t xz1_q, yz1_q;
  logic             v1_q;
  logic             rdy1;

  // stage 2: products
  ctpi_pkg::dn_t    dnq, dnr;
  ctpi_pkg::ca_t    a2_d, a2_q;
  ctpi_pkg::cb_t    pb1_d, pb2_d, pc1_d, pc2_d;
  ctpi_pkg::cb_t    pb1_q, pb2_q, pc1_q, pc2_q;
  ctpi_pkg::cd_t    pd1_d, pd2_d, pd3_d;
  ctpi_pkg::cd_t    pd1_q, pd2_q, pd3_q;
  ctpi_pkg::norm_t  nz2_q;
  ctpi_pkg::coord_t xz2_q, yz2_q;
  logic             v2_q;
  logic             rdy2;

  // stage 3: coefficient sums
  ctpi_pkg::coeff_t coeff_d, coeff_q;
  logic             v3_q;
  logic             rdy3;

  // a stage takes new data when empty or when its content moves on
  assign rdy3       = !v3_q || ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_comb begin
    xp = ctpi_pkg::coord_t'(in_i.p_x[ctpi_pkg::COORD_W-1:0]);
    yp = ctpi_pkg::coord_t'(in_i.p_y[ctpi_pkg::COORD_W-1:0]);
    xq = ctpi_pkg::coord_t'(in_i.q_x[ctpi_pkg::COORD_W-1:0]);
    yq = ctpi_pkg::coord_t'(in_i.q_y[ctpi_pkg::COORD_W-1:0]);
    xr = ctpi_pkg::coord_t'(in_i.r_x[ctpi_pkg::COORD_W-1:0]);
    yr = ctpi_pkg::coord_t'(in_i.r_y[ctpi_pkg::COORD_W-1:0]);
    xz = ctpi_pkg::coord_t'(in_i.query_x[ctpi_pkg::COORD_W-1:0]);
    yz = ctpi_pkg::coord_t'(in_i.query_y[ctpi_pkg::COORD_W-1:0]);

    dxq_d = ctpi_pkg::diff_t'(xq) - ctpi_pkg::diff_t'(xp);
    dyq_d = ctpi_pkg::diff_t'(yq) - ctpi_pkg::diff_t'(yp);
    dxr_d = ctpi_pkg::diff_t'(xr) - ctpi_pkg::diff_t'(xp);
    dyr_d = ctpi_pkg::diff_t'(yr) - ctpi_pkg::diff_t'(yp);

    np1_d = ctpi_pkg::norm_t'(xp) * ctpi_pkg::norm_t'(xp)
          + ctpi_pkg::norm_t'(yp) * ctpi_pkg::norm_t'(yp);
    nq1_d = ctpi_pkg::norm_t'(xq) * ctpi_pkg::norm_t'(xq)
          + ctpi_pkg::norm_t'(yq) * ctpi_pkg::norm_t'(yq);
    nr1_d = ctpi_pkg::norm_t'(xr) * ctpi_pkg::norm_t'(xr)
          + ctpi_pkg::norm_t'(yr) * ctpi_pkg::norm_t'(yr);
    nz1_d = ctpi_pkg::norm_t'(xz) * ctpi_pkg::norm_t'(xz)
          + ctpi_pkg::norm_t'(yz) * ctpi_pkg::norm_t'(yz);

    // minors of the n column in det[n x y]
    k1_d = ctpi_pkg::cross_t'(xq) * ctpi_pkg::cross_t'(yr)
         - ctpi_pkg::cross_t'(xr) * ctpi_pkg::cross_t'(yq);
    k2_d = ctpi_pkg::cross_t'(xp) * ctpi_pkg::cross_t'(yr)
         - ctpi_pkg::cross_t'(xr) * ctpi_pkg::cross_t'(yp);
    k3_d = ctpi_pkg::cross_t'(xp) * ctpi_pkg::cross_t'(yq)
         - ctpi_pkg::cross_t'(xq) * ctpi_pkg::cross_t'(yp);
  end

  always_comb begin
    dnq   = ctpi_pkg::dn_t'(nq1_q) - ctpi_pkg::dn_t'(np1_q);
    dnr   = ctpi_pkg::dn_t'(nr1_q) - ctpi_pkg::dn_t'(np1_q);
    a2_d  = ctpi_pkg::ca_t'(dxq_q) * ctpi_pkg::ca_t'(dyr_q)
          - ctpi_pkg::ca_t'(dyq_q) * ctpi_pkg::ca_t'(dxr_q);
    pb1_d = ctpi_pkg::cb_t'(dnq) * ctpi_pkg::cb_t'(dyr_q);
    pb2_d = ctpi_pkg::cb_t'(dyq_q) * ctpi_pkg::cb_t'(dnr);
    pc1_d = ctpi_pkg::cb_t'(dnq) * ctpi_pkg::cb_t'(dxr_q);
    pc2_d = ctpi_pkg::cb_t'(dxq_q) * ctpi_pkg::cb_t'(dnr);
    pd1_d = ctpi_pkg::cd_t'(np1_q) * ctpi_pkg::cd_t'(k1_q);
    pd2_d = ctpi_pkg::cd_t'(nq1_q) * ctpi_pkg::cd_t'(k2_q);
    pd3_d = ctpi_pkg::cd_t'(nr1_q) * ctpi_pkg::cd_t'(k3_q);
  end

  always_comb begin
    coeff_d.a  = a2_q;
    coeff_d.b  = pb2_q - pb1_q;
    coeff_d.c  = pc1_q - pc2_q;
    // d is minus the cofactor expansion along the n column
    coeff_d.d  = pd2_q - pd1_q - pd3_q;
    coeff_d.nz = nz2_q;
    coeff_d.xz = xz2_q;
    coeff_d.yz = yz2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      dxq_q <= dxq_d;
      dyq_q <= dyq_d;
      dxr_q <= dxr_d;
      dyr_q <= dyr_d;
      np1_q <= np1_d;
      nq1_q <= nq1_d;
      nr1_q <= nr1_d;
      nz1_q <= nz1_d;
      k1_q  <= k1_d;
      k2_q  <= k2_d;
      k3_q  <= k3_d;
      xz1_q <= xz;
      yz1_q <= yz;
    end
    if (rdy2 && v1_q) begin
      a2_q  <= a2_d;
      pb1_q <= pb1_d;
      pb2_q <= pb2_d;
      pc1_q <= pc1_d;
      pc2_q <= pc2_d;
      pd1_q <= pd1_d;
      pd2_q <= pd2_d;
      pd3_q <= pd3_d;
      nz2_q <= nz1_q;
      xz2_q <= xz1_q;
      yz2_q <= yz1_q;
    end
    if (rdy3 && v2_q) begin
      coeff_q <= coeff_d;
    end
  end

  assign valid_o = v3_q;
  assign coeff_o = coeff_q;

endmodule

`default_nettype wire

[src/ctpi_eval.sv]
`default_nettype none

module ctpi_eval (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              invert_i,
  input  wire              valid_i,
  output logic             ready_o,
  input  wire ctpi_pkg::coeff_t coeff_i,
  ctpi_out_if.source       out_o
);

  // stage 4: the three products of f
  ctpi_pkg::f_t  fa_d, fb_d, fc_d;
  ctpi_pkg::f_t  fa_q, fb_q, fc_q;
  ctpi_pkg::ca_t a4_q;
  ctpi_pkg::cb_t b4_q, c4_q;
  ctpi_pkg::cd_t d4_q;
  logic          v4_q;
  logic          rdy4;

  // stage 5: sum, sign and output register
  ctpi_pkg::f_t     f_sum;
  logic             f_neg;
  logic             f_zero;
  ctpi_pkg::out_a_t a_out_d, a_out_q;
  ctpi_pkg::out_b_t b_out_d, b_out_q;
  ctpi_pkg::out_b_t c_out_d, c_out_q;
  ctpi_pkg::out_d_t d_out_d, d_out_q;
  logic             inside_d, inside_q;
  logic             v5_q;
  logic             rdy5;

  assign rdy5    = !v5_q || out_o.ready;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;

  always_comb begin
    fa_d = ctpi_pkg::f_t'(coeff_i.a) * ctpi_pkg::f_t'(coeff_i.nz);
    fb_d = ctpi_pkg::f_t'(coeff_i.b) * ctpi_pkg::f_t'(coeff_i.xz);
    fc_d = ctpi_pkg::f_t'(coeff_i.c) * ctpi_pkg::f_t'(coeff_i.yz);
  end

  always_comb begin
    f_sum  = fa_q + fb_q + fc_q + ctpi_pkg::f_t'(d4_q);
    f_neg  = f_sum[ctpi_pkg::F_W-1];
    f_zero = (f_sum == '0);
    a_out_d = ctpi_pkg::out_a_t'(a4_q);
    b_out_d = ctpi_pkg::out_b_t'(b4_q);
    c_out_d = ctpi_pkg::out_b_t'(c4_q);
    d_out_d = ctpi_pkg::out_d_t'(d4_q);
    // negated coefficients negate f, so the test flips to f > 0
    if (invert_i) begin
      a_out_d  = -a_out_d;
      b_out_d  = -b_out_d;
      c_out_d  = -c_out_d;
      d_out_d  = -d_out_d;
      inside_d = !f_neg && !f_zero;
    end else begin
      inside_d = f_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= valid_i;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      fa_q <= fa_d;
      fb_q <= fb_d;
      fc_q <= fc_d;
      a4_q <= coeff_i.a;
      b4_q <= coeff_i.b;
      c4_q <= coeff_i.c;
      d4_q <= coeff_i.d;
    end
    if (rdy5 && v4_q) begin
      a_out_q  <= a_out_d;
      b_out_q  <= b_out_d;
      c_out_q  <= c_out_d;
      d_out_q  <= d_out_d;
      inside_q <= inside_d;
    end
  end

  assign out_o.valid     = v5_q;
  assign out_o.coeff_a   = a_out_q;
  assign out_o.coeff_b   = b_out_q;
  assign out_o.coeff_c   = c_out_q;
  assign out_o.coeff_d   = d_out_q;
  assign out_o.is_inside = inside_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    ctpi_pkg::in_field_t px, py, qx, qy, rx, ry, zx, zy;
  } points_t;

  typedef struct {
    ctpi_pkg::out_a_t a;
    ctpi_pkg::out_b_t b;
    ctpi_pkg::out_b_t c;
    ctpi_pkg::out_d_t d;
    logic             is_in;
  } circle_t;

  typedef enum {SINK_OPEN, SINK_BUSY, SINK_CHOKED, SINK_TOGGLE} sink_mode_e;

  // predicts the circle for every accepted set of points and checks the results in order
  class circle_tracker;
    bit        flip;
    circle_t   pending_circles[$];
    int        mismatches;
    int        failures;

    function longint coord(ctpi_pkg::in_field_t v);
      ctpi_pkg::coord_t c;
      c = v[ctpi_pkg::COORD_W-1:0];
      return longint'(c);
    endfunction

    function longint det3(longint a0, longint a1, longint a2,
                          longint b0, longint b1, longint b2,
                          longint c0, longint c1, longint c2);
      return a0 * b1 * c2 + a1 * b2 * c0 + a2 * b0 * c1
           - a0 * b2 * c1 - a1 * b0 * c2 - a2 * b1 * c0;
    endfunction

    function circle_t fit_circle(points_t p);
      longint xp, yp, xq, yq, xr, yr, xz, yz;
      longint np, nq, nr, a, b, c, d, f;
      circle_t r;
      xp = coord(p.px);
      yp = coord(p.py);
      xq = coord(p.qx);
      yq = coord(p.qy);
      xr = coord(p.rx);
      yr = coord(p.ry);
      xz = coord(p.zx);
      yz = coord(p.zy);
      np = xp * xp + yp * yp;
      nq = xq * xq + yq * yq;
      nr = xr * xr + yr * yr;
      a = det3(xp, yp, 1, xq, yq, 1, xr, yr, 1);
      b = -det3(np, yp, 1, nq, yq, 1, nr, yr, 1);
      c = det3(np, xp, 1, nq, xq, 1, nr, xr, 1);
      d = -det3(np, xp, yp, nq, xq, yq, nr, xr, yr);
      if (flip) begin
        a = -a;
        b = -b;
        c = -c;
        d = -d;
      end
      f = a * (xz * xz + yz * yz) + b * xz + c * yz + d;
      r.a = ctpi_pkg::out_a_t'(a);
      r.b = ctpi_pkg::out_b_t'(b);
      r.c = ctpi_pkg::out_b_t'(c);
      r.d = ctpi_pkg::out_d_t'(d);
      r.is_in = (f < 0);
      return r;
    endfunction

    function void note_points(points_t p);
      pending_circles.push_back(fit_circle(p));
    endfunction

    function int pending();
      return pending_circles.size();
    endfunction

    function void check_circle(circle_t got);
      circle_t want;
      if (pending_circles.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: a=%0d b=%0d c=%0d d=%0d inside=%0b",
                   got.a, got.b, got.c, got.d, got.is_in);
        return;
      end
      want = pending_circles.pop_front();
      if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
          got.d !== want.d || got.is_in !== want.is_in) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp a=%0d b=%0d c=%0d d=%0d inside=%0b",
                    " / got a=%0d b=%0d c=%0d d=%0d inside=%0b"},
                   want.a, want.b, want.c, want.d, want.is_in,
                   got.a, got.b, got.c, got.d, got.is_in);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic invert_we;
  logic invert_wdata;

  ctpi_in_if  in_if ();
  ctpi_out_if out_if ();

  circle_three_points_inside_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .invert_we_i    (invert_we),
    .invert_wdata_i (invert_wdata),
    .in_i           (in_if),
    .out_o          (out_if)
  );

  circle_tracker board;
  points_t       directed[$];
  sink_mode_e    sink_mode = SINK_OPEN;
  int            sink_left = 0;
  int            sink_tick = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic ctpi_pkg::in_field_t rnd(int lo, int hi);
    return ctpi_pkg::in_field_t'(int'($urandom_range(hi - lo)) + lo);
  endfunction

  function automatic ctpi_pkg::in_field_t corner();
    case ($urandom_range(4))
      0: return ctpi_pkg::in_field_t'(-2048);
      1: return ctpi_pkg::in_field_t'(2047);
      2: return ctpi_pkg::in_field_t'(0);
      3: return ctpi_pkg::in_field_t'(-1);
      default: return ctpi_pkg::in_field_t'(1);
    endcase
  endfunction

  function automatic points_t pts(int px, int py, int qx, int qy,
                                  int rx, int ry, int zx, int zy);
    points_t p;
    p = '{ctpi_pkg::in_field_t'(px), ctpi_pkg::in_field_t'(py),
          ctpi_pkg::in_field_t'(qx), ctpi_pkg::in_field_t'(qy),
          ctpi_pkg::in_field_t'(rx), ctpi_pkg::in_field_t'(ry),
          ctpi_pkg::in_field_t'(zx), ctpi_pkg::in_field_t'(zy)};
    return p;
  endfunction

  function automatic points_t random_points();
    points_t p;
    int sel, dx, dy, ox, oy, m, n;
    sel = $urandom_range(99);
    p = '{rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047),
          rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047)};
    if (sel < 50) begin
    end else if (sel < 65) begin
      // tiny grid, lots of collinear sets and queries on the boundary
      p = '{rnd(-4, 4), rnd(-4, 4), rnd(-4, 4), rnd(-4, 4),
            rnd(-4, 4), rnd(-4, 4), rnd(-4, 4), rnd(-4, 4)};
    end else if (sel < 80) begin
      dx = int'($urandom_range(16)) - 8;
      dy = int'($urandom_range(16)) - 8;
      ox = int'($urandom_range(2000)) - 1000;
      oy = int'($urandom_range(2000)) - 1000;
      m  = int'($urandom_range(200)) - 100;
      n  = int'($urandom_range(200)) - 100;
      p.px = ctpi_pkg::in_field_t'(ox);
      p.py = ctpi_pkg::in_field_t'(oy);
      p.qx = ctpi_pkg::in_field_t'(ox + m * dx);
      p.qy = ctpi_pkg::in_field_t'(oy + m * dy);
      p.rx = ctpi_pkg::in_field_t'(ox + n * dx);
      p.ry = ctpi_pkg::in_field_t'(oy + n * dy);
    end else if (sel < 90) begin
      // query sits on one of the defining points, so f is zero
      case ($urandom_range(2))
        0: begin p.zx = p.px; p.zy = p.py; end
        1: begin p.zx = p.qx; p.zy = p.qy; end
        default: begin p.zx = p.rx; p.zy = p.ry; end
      endcase
    end else if (sel < 95) begin
      if ($urandom_range(1)) begin
        p.qx = p.px;
        p.qy = p.py;
      end else begin
        p.rx = p.qx;
        p.ry = p.qy;
      end
    end else begin
      p = '{corner(), corner(), corner(), corner(),
            corner(), corner(), corner(), corner()};
    end
    return p;
  endfunction

  task automatic send_points(input points_t p);
    in_if.valid   <= 1'b1;
    in_if.p_x     <= p.px;
    in_if.p_y     <= p.py;
    in_if.q_x     <= p.qx;
    in_if.q_y     <= p.qy;
    in_if.r_x     <= p.rx;
    in_if.r_y     <= p.ry;
    in_if.query_x <= p.zx;
    in_if.query_y <= p.zy;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_points(p);
  endtask

  task automatic pause_sender(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_invert(input bit v);
    invert_we    <= 1'b1;
    invert_wdata <= v;
    @(posedge clk_i);
    invert_we    <= 1'b0;
    board.flip = v;
  endtask

  task automatic random_phase(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(40, 1);
      repeat (burst) begin
        send_points(random_points());
        sent++;
      end
      case ($urandom_range(3))
        0: begin end
        1, 2: pause_sender($urandom_range(4, 1));
        default: pause_sender($urandom_range(24, 5));
      endcase
    end
  endtask

  // result side: sample transfers before this edge's updates, then pick next ready
  always @(posedge clk_i) begin
    circle_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.a     = out_if.coeff_a;
      got.b     = out_if.coeff_b;
      got.c     = out_if.coeff_c;
      got.d     = out_if.coeff_d;
      got.is_in = out_if.is_inside;
      board.check_circle(got);
    end
    sink_tick <= sink_tick + 1;
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(3));
      sink_left <= $urandom_range(200, 16);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_if.ready <= 1'b1;
      SINK_BUSY:   out_if.ready <= ($urandom_range(3) != 0);
      SINK_CHOKED: out_if.ready <= ($urandom_range(7) == 0);
      default:     out_if.ready <= sink_tick[2];
    endcase
  end

  initial begin
    int i;
    board = new();
    rst_ni          = 1'b0;
    invert_we       = 1'b0;
    invert_wdata    = 1'b0;
    in_if.valid     = 1'b0;
    in_if.p_x       = '0;
    in_if.p_y       = '0;
    in_if.q_x       = '0;
    in_if.q_y       = '0;
    in_if.r_x       = '0;
    in_if.r_y       = '0;
    in_if.query_x   = '0;
    in_if.query_y   = '0;

    // small circle through the origin: centre, boundary, outside
    directed.push_back(pts(0, 0, 2, 0, 0, 2, 1, 1));
    directed.push_back(pts(0, 0, 2, 0, 0, 2, 2, 2));
    directed.push_back(pts(0, 0, 2, 0, 0, 2, 5, -3));
    // collinear: both sides of the line and on it
    directed.push_back(pts(0, 0, 1, 1, 2, 2, 0, 1));
    directed.push_back(pts(0, 0, 1, 1, 2, 2, 1, 0));
    directed.push_back(pts(0, 0, 1, 1, 2, 2, 3, 3));
    // coincident points give all-zero coefficients, then extreme corner coordinates
    directed.push_back(pts(5, 5, 5, 5, 5, 5, 0, 0));
    directed.push_back(pts(7, -3, 7, -3, 100, 20, 1, 1));
    directed.push_back(pts(-2048, -2048, 2047, -2048, -2048, 2047, 0, 0));
    directed.push_back(pts(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047));
    directed.push_back(pts(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048));
    directed.push_back(pts(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048));
    directed.push_back(pts(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047));
    directed.push_back(pts(-2048, 0, 2047, 0, 0, 2047, -2048, -2048));
    directed.push_back(pts(-2048, 2047, 2047, -2048, 0, -1, 2047, 2047));
    directed.push_back(pts(-1, -1, 1, -1, -1, 1, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_invert(1'b0);
    foreach (directed[k]) send_points(directed[k]);
    drain();

    set_invert(1'b1);
    for (i = 0; i < 9; i++) send_points(directed[i]);
    drain();

    set_invert(1'b0);
    random_phase(450);
    drain();
    set_invert(1'b1);
    random_phase(450);
    drain();
    set_invert(1'b1);
    random_phase(400);
    drain();
    set_invert(1'b0);
    random_phase(450);
    drain();

    repeat (20) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
